// ----- hw/rtl/mpe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mpe_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int PIX_W       = 12;
  localparam int COORD_W     = 32;
  localparam int STEP_W      = 31;
  localparam int ITER_W      = 16;
  localparam int COLOR_W     = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int Z_W         = COORD_W + 2;
  localparam int MAG_W       = FRAC_BITS + 2;
  localparam int SQ_W        = 2 * MAG_W - FRAC_BITS;
  localparam int CPROD_W     = STEP_W + PIX_W;
  localparam int CSUM_W      = CPROD_W + 1;
  localparam int DIVD_W      = ITER_W + COLOR_W;
  localparam int DIV_STEPS   = COLOR_W;

  localparam logic [COLOR_W-1:0] COLOR_SCALE = COLOR_W'(20'h912FF);
  localparam logic [Z_W-1:0]     TWO_FX      = Z_W'(2) << FRAC_BITS;
  localparam logic [SQ_W:0]      FOUR_FX     = (SQ_W + 1)'(4) << FRAC_BITS;

  localparam logic signed [COORD_W-1:0] X_MIN_RST = -32'sd536870912;
  localparam logic [STEP_W-1:0]         X_STEP_RST = 31'd1073742;
  localparam logic signed [COORD_W-1:0] Y_MIN_RST = -32'sd536870912;
  localparam logic [STEP_W-1:0]         Y_STEP_RST = 31'd1073742;
  localparam logic [ITER_W-1:0]         MAX_ITER_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN    = 3'd0,
    CFG_X_STEP   = 3'd1,
    CFG_Y_MIN    = 3'd2,
    CFG_Y_STEP   = 3'd3,
    CFG_MAX_ITER = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] column;
    logic [PIX_W-1:0] row;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_column;
    logic [PIX_W-1:0]   pixel_row;
    logic [ITER_W-1:0]  iteration_count;
    logic [COLOR_W-1:0] pixel_color;
  } pixel_out_t;

  typedef struct packed {
    logic               valid;
    logic [DIVD_W-1:0]  rem;
    logic [DIVD_W-1:0]  dsh;
    logic [COLOR_W-1:0] quo;
  } div_stage_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mandelbrot_pixel_engine_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each iteration of the shared datapath runs a multiply state, then an update state;
// the colour divide runs through a 20-cell chain, one quotient bit per cell.
// One pixel is in flight at a time.
// A new input is taken while a result waits in the output register.
// Synchronous reset clears control and loads the register defaults.
module mandelbrot_pixel_engine_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire mpe_pkg::pixel_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output mpe_pkg::pixel_out_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mpe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CMUL = 8'b0000_0010,
    ST_CADD = 8'b0000_0100,
    ST_IMUL = 8'b0000_1000,
    ST_IUPD = 8'b0001_0000,
    ST_PMUL = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic signed [mpe_pkg::COORD_W-1:0] x_min, y_min;
  logic [mpe_pkg::STEP_W-1:0]         x_step, y_step;
  logic [mpe_pkg::ITER_W-1:0]         max_iter;

  logic [mpe_pkg::PIX_W-1:0]   col, row;
  logic [mpe_pkg::CPROD_W-1:0] px, py;
  logic [mpe_pkg::COORD_W-1:0] cx, cy;
  logic [mpe_pkg::Z_W-1:0]     x, y;
  logic [mpe_pkg::ITER_W-1:0]  n;
  logic [mpe_pkg::SQ_W-1:0]    x2, y2, xy;
  logic                        big, neg;
  logic [mpe_pkg::DIVD_W-1:0]  cprod;
  logic                        div_go;
  logic [mpe_pkg::COLOR_W-1:0] color;

  logic [mpe_pkg::Z_W-1:0]       ax, ay;
  logic [2*mpe_pkg::MAG_W-1:0]   pxx, pyy, pxy;
  logic [mpe_pkg::SQ_W:0]        mag2;
  logic [mpe_pkg::Z_W-1:0]       xy_term, xn, yn;
  logic                          div_done;
  logic [mpe_pkg::COLOR_W-1:0]   div_q;
  logic                          load_out;

  function automatic logic [mpe_pkg::COORD_W-1:0] sat_coord(
    input logic [mpe_pkg::COORD_W-1:0] base,
    input logic [mpe_pkg::CPROD_W-1:0] prod
  );
    logic [mpe_pkg::CSUM_W-1:0] s;
    logic [mpe_pkg::CSUM_W-mpe_pkg::COORD_W:0] top;
    s = {{(mpe_pkg::CSUM_W-mpe_pkg::COORD_W){base[mpe_pkg::COORD_W-1]}}, base}
        + {1'b0, prod};
    top = s[mpe_pkg::CSUM_W-1:mpe_pkg::COORD_W-1];
    if (!s[mpe_pkg::CSUM_W-1] && (|top)) begin
      sat_coord = {1'b0, {(mpe_pkg::COORD_W-1){1'b1}}};
    end else if (s[mpe_pkg::CSUM_W-1] && !(&top)) begin
      sat_coord = {1'b1, {(mpe_pkg::COORD_W-1){1'b0}}};
    end else begin
      sat_coord = s[mpe_pkg::COORD_W-1:0];
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min    <= mpe_pkg::X_MIN_RST;
      x_step   <= mpe_pkg::X_STEP_RST;
      y_min    <= mpe_pkg::Y_MIN_RST;
      y_step   <= mpe_pkg::Y_STEP_RST;
      max_iter <= mpe_pkg::MAX_ITER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpe_pkg::CFG_X_MIN:    x_min    <= cfg_data;
        mpe_pkg::CFG_X_STEP:   x_step   <= cfg_data[mpe_pkg::STEP_W-1:0];
        mpe_pkg::CFG_Y_MIN:    y_min    <= cfg_data;
        mpe_pkg::CFG_Y_STEP:   y_step   <= cfg_data[mpe_pkg::STEP_W-1:0];
        mpe_pkg::CFG_MAX_ITER: max_iter <= cfg_data[mpe_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign ax   = x[mpe_pkg::Z_W-1] ? (~x + 1'b1) : x;
  assign ay   = y[mpe_pkg::Z_W-1] ? (~y + 1'b1) : y;
  assign pxx  = (2*mpe_pkg::MAG_W)'(ax[mpe_pkg::MAG_W-1:0])
                * (2*mpe_pkg::MAG_W)'(ax[mpe_pkg::MAG_W-1:0]);
  assign pyy  = (2*mpe_pkg::MAG_W)'(ay[mpe_pkg::MAG_W-1:0])
                * (2*mpe_pkg::MAG_W)'(ay[mpe_pkg::MAG_W-1:0]);
  assign pxy  = (2*mpe_pkg::MAG_W)'(ax[mpe_pkg::MAG_W-1:0])
                * (2*mpe_pkg::MAG_W)'(ay[mpe_pkg::MAG_W-1:0]);
  assign mag2 = {1'b0, x2} + {1'b0, y2};
  assign xy_term = mpe_pkg::Z_W'({xy, 1'b0});
  assign xn = {2'b00, x2} - {2'b00, y2} + {{2{cx[mpe_pkg::COORD_W-1]}}, cx};
  assign yn = (neg ? (~xy_term + 1'b1) : xy_term) + {{2{cy[mpe_pkg::COORD_W-1]}}, cy};
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_CMUL;
      ST_CMUL: state_next = ST_CADD;
      ST_CADD: state_next = ST_IMUL;
      ST_IMUL: state_next = (n >= max_iter) ? ST_PMUL : ST_IUPD;
      ST_IUPD: state_next = (big || (mag2 > mpe_pkg::FOUR_FX)) ? ST_PMUL : ST_IMUL;
      ST_PMUL: state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_DONE;
      ST_DONE: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      div_go <= (state == ST_PMUL);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        col <= in_data.column;
        row <= in_data.row;
        n   <= '0;
      end
      ST_CMUL: begin
        px <= mpe_pkg::CPROD_W'(x_step) * mpe_pkg::CPROD_W'(col);
        py <= mpe_pkg::CPROD_W'(y_step) * mpe_pkg::CPROD_W'(row);
      end
      ST_CADD: begin
        cx <= sat_coord(x_min, px);
        cy <= sat_coord(y_min, py);
        x  <= mpe_pkg::Z_W'(signed'(sat_coord(x_min, px)));
        y  <= mpe_pkg::Z_W'(signed'(sat_coord(y_min, py)));
      end
      ST_IMUL: begin
        big <= (ax > mpe_pkg::TWO_FX) || (ay > mpe_pkg::TWO_FX);
        neg <= x[mpe_pkg::Z_W-1] ^ y[mpe_pkg::Z_W-1];
        x2  <= pxx[mpe_pkg::FRAC_BITS+mpe_pkg::SQ_W-1:mpe_pkg::FRAC_BITS];
        y2  <= pyy[mpe_pkg::FRAC_BITS+mpe_pkg::SQ_W-1:mpe_pkg::FRAC_BITS];
        xy  <= pxy[mpe_pkg::FRAC_BITS+mpe_pkg::SQ_W-1:mpe_pkg::FRAC_BITS];
      end
      ST_IUPD: begin
        if (!(big || (mag2 > mpe_pkg::FOUR_FX))) begin
          x <= xn;
          y <= yn;
          n <= n + 1'b1;
        end
      end
      ST_PMUL: begin
        cprod <= mpe_pkg::DIVD_W'(n) * mpe_pkg::DIVD_W'(mpe_pkg::COLOR_SCALE);
      end
      ST_DIV: begin
        color <= (max_iter == '0) ? '0 : div_q;
      end
      default: ;
    endcase
    if (load_out) begin
      out_data.pixel_column    <= col;
      out_data.pixel_row       <= row;
      out_data.iteration_count <= n;
      out_data.pixel_color     <= color;
    end
  end

  mpe_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (cprod),
    .divisor  (max_iter),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef ASSERT_OFF
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider result outside divide state");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.iteration_count <= max_iter)
    else $error("iteration count above limit");

  a_full_color: assert property (@(posedge clk) disable iff (rst)
    (out_valid && max_iter != '0 && out_data.iteration_count == max_iter)
    |-> out_data.pixel_color == mpe_pkg::COLOR_SCALE)
    else $error("colour at limit is not full scale");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/mpe_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mpe_div_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mpe_pkg::div_stage_t prev,
  output mpe_pkg::div_stage_t      nxt
);

  logic ge;

  assign ge = prev.rem >= prev.dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      nxt.valid <= 1'b0;
    end else begin
      nxt.valid <= prev.valid;
    end
    nxt.rem <= ge ? prev.rem - prev.dsh : prev.rem;
    nxt.dsh <= prev.dsh >> 1;
    nxt.quo <= {prev.quo[mpe_pkg::COLOR_W-2:0], ge};
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mpe_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mpe_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [mpe_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [mpe_pkg::ITER_W-1:0]   divisor,
  output logic                              done,
  output logic [mpe_pkg::COLOR_W-1:0]       quotient
);

  mpe_pkg::div_stage_t stage [0:mpe_pkg::DIV_STEPS];

  always_comb begin
    stage[0].valid = start;
    stage[0].rem   = dividend;
    stage[0].dsh   = mpe_pkg::DIVD_W'({divisor, {(mpe_pkg::COLOR_W-1){1'b0}}});
    stage[0].quo   = '0;
  end

  for (genvar i = 0; i < mpe_pkg::DIV_STEPS; i++) begin : g_cell
    mpe_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (stage[i]),
      .nxt  (stage[i+1])
    );
  end

  assign done     = stage[mpe_pkg::DIV_STEPS].valid;
  assign quotient = stage[mpe_pkg::DIV_STEPS].quo;

endmodule
`default_nettype wire

// ----- tb/tb_mandelbrot_pixel_engine_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_mandelbrot_pixel_engine_unit;

  localparam int CFG_IDX_TOP = 7;

  class escape_scoreboard;
    mpe_pkg::pixel_out_t pending_pixels[$];
    longint xmin, ymin;
    longint unsigned xstep, ystep, limit;
    int mismatches;

    function new();
      xmin = mpe_pkg::X_MIN_RST;
      ymin = mpe_pkg::Y_MIN_RST;
      xstep = mpe_pkg::X_STEP_RST;
      ystep = mpe_pkg::Y_STEP_RST;
      limit = mpe_pkg::MAX_ITER_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [mpe_pkg::CFG_IDX_W-1:0] idx,
                          logic [mpe_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mpe_pkg::CFG_X_MIN: xmin = longint'(signed'(data));
        mpe_pkg::CFG_X_STEP: xstep = data[mpe_pkg::STEP_W-1:0];
        mpe_pkg::CFG_Y_MIN: ymin = longint'(signed'(data));
        mpe_pkg::CFG_Y_STEP: ystep = data[mpe_pkg::STEP_W-1:0];
        mpe_pkg::CFG_MAX_ITER: limit = data[mpe_pkg::ITER_W-1:0];
        default: ;
      endcase
    endfunction

    function longint map_coord(longint base, longint unsigned step, int unsigned idx);
      longint v;
      v = base + longint'(step) * longint'(idx);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned escape_iters(longint cx, longint cy);
      longint x, y, xy_term;
      longint unsigned ax, ay, x2, y2, xy, n;
      longint unsigned two, four;
      two = 64'd2 << mpe_pkg::FRAC_BITS;
      four = 64'd4 << mpe_pkg::FRAC_BITS;
      x = cx;
      y = cy;
      n = 0;
      while (n < limit) begin
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        if (ax > two || ay > two) break;
        x2 = (ax * ax) >> mpe_pkg::FRAC_BITS;
        y2 = (ay * ay) >> mpe_pkg::FRAC_BITS;
        if (x2 + y2 > four) break;
        xy = (ax * ay) >> mpe_pkg::FRAC_BITS;
        xy_term = longint'(xy * 2);
        if ((x < 0) != (y < 0)) xy_term = -xy_term;
        x = longint'(x2) - longint'(y2) + cx;
        y = xy_term + cy;
        n++;
      end
      return n;
    endfunction

    function void note_pixel(mpe_pkg::pixel_in_t px);
      mpe_pkg::pixel_out_t e;
      longint unsigned n;
      n = escape_iters(map_coord(xmin, xstep, px.column), map_coord(ymin, ystep, px.row));
      e.pixel_column = px.column;
      e.pixel_row = px.row;
      e.iteration_count = n[mpe_pkg::ITER_W-1:0];
      e.pixel_color = (limit == 0) ? '0
                      : mpe_pkg::COLOR_W'((n * mpe_pkg::COLOR_SCALE) / limit);
      pending_pixels.push_back(e);
    endfunction

    function void check_pixel(mpe_pkg::pixel_out_t got);
      mpe_pkg::pixel_out_t e;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      e = pending_pixels.pop_front();
      if (got.pixel_column !== e.pixel_column || got.pixel_row !== e.pixel_row ||
          got.iteration_count !== e.iteration_count || got.pixel_color !== e.pixel_color) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  mpe_pkg::pixel_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  mpe_pkg::pixel_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [mpe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mpe_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic quiet = 0;
  escape_scoreboard sb = new();

  always #4 clk = ~clk;

  mandelbrot_pixel_engine_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_pixel(out_data);
      out_stall <= !quiet && ($urandom_range(99) < 26);
    end
  end

  initial begin
    #40_000_000;
    $display("FAIL mandelbrot_pixel_engine_unit");
    $finish;
  end

  task automatic cfg_write(logic [mpe_pkg::CFG_IDX_W-1:0] idx,
                           logic [mpe_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_pixel(int unsigned col, int unsigned row);
    mpe_pkg::pixel_in_t px;
    px.column = col[mpe_pkg::PIX_W-1:0];
    px.row = row[mpe_pkg::PIX_W-1:0];
    if (!quiet && $urandom_range(99) < 26) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(px);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_window(int xm, int unsigned xs, int ym, int unsigned ys, int unsigned lim);
    cfg_write(mpe_pkg::CFG_X_MIN, xm);
    cfg_write(mpe_pkg::CFG_X_STEP, xs);
    cfg_write(mpe_pkg::CFG_Y_MIN, ym);
    cfg_write(mpe_pkg::CFG_Y_STEP, ys);
    cfg_write(mpe_pkg::CFG_MAX_ITER, lim);
  endtask

  initial begin
    int unsigned lim;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    send_pixel(500, 500);
    send_pixel(400, 600);
    send_pixel(2730, 1365);
    send_pixel(1365, 2730);
    drain();

    for (int i = mpe_pkg::CFG_MAX_ITER + 1; i <= CFG_IDX_TOP; i++)
      cfg_write(mpe_pkg::CFG_IDX_W'(i), $urandom());
    send_pixel(500, 500);
    send_pixel(300, 520);
    drain();

    set_window(0, 0, 0, 0, 16'hFFFF);
    send_pixel(0, 0);
    drain();
    set_window(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 16'hFFFF);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    send_pixel(1, 0);
    drain();

    set_window(32'hE000_0000, 1 << 20, 32'hE000_0000, 1 << 20, 0);
    send_pixel(512, 512);
    send_pixel(0, 0);
    drain();
    cfg_write(mpe_pkg::CFG_MAX_ITER, 1);
    send_pixel(512, 512);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    drain();
    set_window(32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);
    send_pixel(0, 0);
    send_pixel(2, 7);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      lim = (ph % 4 == 3) ? $urandom_range(1, 16) : $urandom_range(1, 200);
      if (ph % 5 == 4)
        set_window($urandom(), $urandom(), $urandom(), $urandom(), lim);
      else
        set_window(-$urandom_range(32'h2800_0000, 0), $urandom_range(1 << 20, 1 << 15),
                   -$urandom_range(32'h2000_0000, 0), $urandom_range(1 << 20, 1 << 15), lim);
      quiet = (ph == 6);
      for (int k = 0; k < 50; k++) begin
        if (ph % 4 == 1 && k < 40)
          send_pixel($urandom_range(511), $urandom_range(511));
        else
          send_pixel($urandom_range(4095), $urandom_range(4095));
        if (ph == 2 && k == 25) begin
          in_valid <= 0;
          while (sb.pending_pixels.size() != 0) @(posedge clk);
        end
      end
      drain();
      quiet = 0;
    end

    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
      $display("PASS mandelbrot_pixel_engine_unit");
    else
      $display("FAIL mandelbrot_pixel_engine_unit");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/mpe_pkg.sv
hw/rtl/mpe_div_cell.sv
hw/rtl/mpe_divider.sv
hw/rtl/mandelbrot_pixel_engine_unit.sv
tb/tb_mandelbrot_pixel_engine_unit.sv
